/* hdl/rrts_pkg.sv */
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants for the rotated rectangle strip hit test
// Action codes, sequencer states and fixed formats.
// ----------------------------------------------------------------------------
`default_nettype none
package rrts_pkg;
  localparam int TRIG_W = 16;
  localparam int CNT_W  = 7;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORNER,   // rotate one corner product per cycle
    ST_RD,       // issue store read
    ST_RDWAIT,   // capture read data
    ST_AREA,     // one product of an area per cycle
    ST_TEST,     // compare area sum
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

/* hdl/rrts_ram.sv */
// ----------------------------------------------------------------------------
// rrts_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rrts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* hdl/rotated_rect_vs_triangle_strip_hit.sv */
// ----------------------------------------------------------------------------
// rotated_rect_vs_triangle_strip_hit: rectangle versus triangle strip overlap
// Holds a strip of vertices and tests a rotated rectangle against it.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// s_axis   in   s_tvalid / s_tready    action, vertex, rect, pivot, size, trig
// m_axis   out  m_tvalid / m_tready    hit, status, stored_count
//
// Clear and append go straight to the result. A query first rotates the four
// corners (four products per corner on one shared multiplier), then walks each
// strip triangle (three reads, four corner tests) and each vertex (one read, two
// half tests), for n-2 triangles and n vertices; a hit ends the walk early.
// s_tready is low from acceptance until the result is taken.
// Reset is synchronous and clears the count; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module rotated_rect_vs_triangle_strip_hit #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // action[1:0], vertex_x, vertex_y, rect_pos_x, rect_pos_y, pivot_x, pivot_y,
  // rect_width, rect_height, rot_cos[15:0], rot_sin[15:0], zero fill
  input  wire logic [((2+8*COORD_WIDTH-2+2*rrts_pkg::TRIG_W+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // hit, status, stored_count[6:0]
  output logic [15:0] m_tdata
);
  import rrts_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int PW  = CW + 6;            // corner coordinate width (exact)
  localparam int DW  = PW + 1;            // coordinate difference
  localparam int MW  = PW + DW;           // area product
  localparam int SW  = MW + 4;            // area sums
  localparam int RW  = CW + 1 + TRIG_W;   // rotation product
  localparam int RSW = RW + 1;

  // field unpack
  logic [1:0]            f_action;
  logic signed [CW-1:0]  f_vx, f_vy, f_px, f_py, f_ox, f_oy;
  logic [CW-2:0]         f_w, f_h;
  logic signed [TRIG_W-1:0] f_cos, f_sin;
  assign f_action = s_tdata[1:0];
  assign f_vx  = s_tdata[2+0*CW +: CW];
  assign f_vy  = s_tdata[2+1*CW +: CW];
  assign f_px  = s_tdata[2+2*CW +: CW];
  assign f_py  = s_tdata[2+3*CW +: CW];
  assign f_ox  = s_tdata[2+4*CW +: CW];
  assign f_oy  = s_tdata[2+5*CW +: CW];
  assign f_w   = s_tdata[2+6*CW +: CW-1];
  assign f_h   = s_tdata[1+7*CW +: CW-1];
  assign f_cos = s_tdata[8*CW +: TRIG_W];
  assign f_sin = s_tdata[8*CW+TRIG_W +: TRIG_W];

  state_t state, state_next;
  logic [NW-1:0] total;
  logic hit, status;
  logic signed [CW-1:0] px, py, ox, oy;
  logic [CW-2:0] rw, rh;
  logic signed [TRIG_W-1:0] cs, sn;
  logic signed [PW-1:0] cx [4];
  logic signed [PW-1:0] cy [4];
  logic [2:0] step;              // corner product index: 0..1 give x, 2..3 give y
  logic [1:0] ci;                // corner index
  logic signed [RSW-1:0] acc;
  // test phase
  logic phase;                   // 0: corners in triangles, 1: vertices in halves
  logic [NW-1:0] k;
  logic [1:0] sub;               // point index within test (corner or half)
  logic [1:0] rd_i;              // which of the three vertices is read
  logic signed [PW-1:0] tx [4];  // a, b, c, p
  logic signed [PW-1:0] ty [4];
  logic [1:0] ar;                // area index 0 whole, 1..3 parts
  logic [1:0] term;
  logic signed [SW-1:0] tsum, whole, parts;

  // ram
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [2*CW-1:0] ram_rd;
  logic accept;
  assign accept = s_tvalid && s_tready;
  assign ram_we = accept && (f_action == ACT_APPEND) && (total < NW'(MAX_VERTICES));

  always_comb begin
    logic [NW-1:0] a;
    a = '0;
    if (ram_we) a = total;
    else if (phase == 1'b0) a = k - NW'(rd_i);
    else a = k;
    ram_addr = a[AW-1:0];
  end

  rrts_ram #(.WIDTH(2*CW), .DEPTH(MAX_VERTICES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata({f_vy, f_vx}), .rdata(ram_rd)
  );

  // shared multiplier
  logic signed [DW-1:0] ma;
  logic signed [PW:0] mb;
  logic signed [MW+1:0] mp;
  assign mp = ma * mb;

  // corner operands
  logic signed [CW+1:0] lx, ly, dx, dy;
  always_comb begin
    lx = (ci == 2'd1 || ci == 2'd2) ? (CW+2)'({1'b0, rw}) : '0;
    ly = (ci == 2'd2 || ci == 2'd3) ? (CW+2)'({1'b0, rh}) : '0;
    dx = lx - (CW+2)'(ox);
    dy = ly - (CW+2)'(oy);
  end

  // area operands: term t uses x of point t times y difference of others
  logic [1:0] i0, i1, i2;
  always_comb begin
    // area 0: a,b,c ; 1: a,b,p ; 2: a,p,c ; 3: p,b,c
    case (ar)
      2'd0: begin i0 = 2'd0; i1 = 2'd1; i2 = 2'd2; end
      2'd1: begin i0 = 2'd0; i1 = 2'd1; i2 = 2'd3; end
      2'd2: begin i0 = 2'd0; i1 = 2'd3; i2 = 2'd2; end
      default: begin i0 = 2'd3; i1 = 2'd1; i2 = 2'd2; end
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    if (state == ST_CORNER) begin
      // step: 0 dx*cs, 1 dy*sn, 2 dx*sn, 3 dy*cs
      ma = (step[0]) ? DW'(dy) : DW'(dx);
      mb = (step[1] ^ step[0]) ? (PW+1)'(sn) : (PW+1)'(cs);
    end else begin
      case (term)
        2'd0: begin ma = DW'(ty[i1]) - DW'(ty[i2]); mb = (PW+1)'(tx[i0]); end
        2'd1: begin ma = DW'(ty[i2]) - DW'(ty[i0]); mb = (PW+1)'(tx[i1]); end
        default: begin ma = DW'(ty[i0]) - DW'(ty[i1]); mb = (PW+1)'(tx[i2]); end
      endcase
    end
  end

  logic signed [SW-1:0] tsum_new, tabs;
  assign tsum_new = tsum + SW'(mp);
  assign tabs = tsum_new[SW-1] ? -tsum_new : tsum_new;
  logic signed [RSW-1:0] acc_new, rnd;
  assign acc_new = (step[1] ^ step[0]) && !step[1] ? acc - RSW'(mp) : acc + RSW'(mp);
  assign rnd = (acc_new + RSW'(8192)) >>> 14;

  logic [NW-1:0] nlim;
  assign nlim = total;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = (f_action == ACT_QUERY) ? ST_CORNER : ST_DONE;
      ST_CORNER: if (step == 3'd3 && ci == 2'd3)
                   state_next = (total < NW'(3)) ? ST_DONE : ST_RD;
      ST_RD:     state_next = ST_RDWAIT;
      ST_RDWAIT: state_next = (phase == 1'b0 && rd_i != 2'd2) ? ST_RD : ST_AREA;
      ST_AREA:   if (term == 2'd2) state_next = (ar == 2'd3) ? ST_TEST : ST_AREA;
      ST_TEST:   begin
        if (parts <= whole) state_next = ST_DONE;
        else if (phase == 1'b0 && sub != 2'd3) state_next = ST_AREA;
        else if (phase == 1'b1 && sub == 2'd0) state_next = ST_AREA;
        else if (phase == 1'b0 && k + NW'(1) < nlim) state_next = ST_RD;
        else if (phase == 1'b0) state_next = ST_RD;
        else if (k + NW'(1) < nlim) state_next = ST_RD;
        else state_next = ST_DONE;
      end
      ST_DONE:   if (m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_DONE);
  assign m_tdata  = {7'd0, CNT_W'(total), status, hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      total <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        hit <= 1'b0;
        // flag an append that finds the store full
        status <= (f_action == ACT_APPEND) && !ram_we;
        case (f_action)
          ACT_CLEAR:  total <= '0;
          ACT_APPEND: if (ram_we) total <= total + NW'(1);
          default:    ;
        endcase
        px <= f_px; py <= f_py; ox <= f_ox; oy <= f_oy;
        rw <= f_w; rh <= f_h; cs <= f_cos; sn <= f_sin;
        step <= '0; ci <= '0; acc <= '0;
        phase <= 1'b0; k <= NW'(2); rd_i <= '0;
      end
      case (state)
        ST_CORNER: begin
          if (step == 3'd1) begin
            cx[ci] <= PW'(rnd) + PW'(px);
            acc <= '0;
            step <= step + 3'd1;
          end else if (step == 3'd3) begin
            cy[ci] <= PW'(rnd) + PW'(py);
            acc <= '0;
            step <= '0;
            ci <= ci + 2'd1;
          end else begin
            acc <= acc_new;
            step <= step + 3'd1;
          end
        end
        ST_RDWAIT: begin
          if (phase == 1'b0) begin
            tx[rd_i] <= PW'($signed(ram_rd[CW-1:0]));
            ty[rd_i] <= PW'($signed(ram_rd[2*CW-1:CW]));
            if (rd_i == 2'd2) begin
              rd_i <= '0;
              tx[3] <= cx[0]; ty[3] <= cy[0];
            end else begin
              rd_i <= rd_i + 2'd1;
            end
          end else begin
            tx[3] <= PW'($signed(ram_rd[CW-1:0]));
            ty[3] <= PW'($signed(ram_rd[2*CW-1:CW]));
            tx[0] <= cx[0]; ty[0] <= cy[0];
            tx[1] <= cx[1]; ty[1] <= cy[1];
            tx[2] <= cx[2]; ty[2] <= cy[2];
          end
          sub <= '0; ar <= '0; term <= '0; tsum <= '0; parts <= '0;
        end
        ST_AREA: begin
          if (term == 2'd2) begin
            term <= '0;
            tsum <= '0;
            ar <= ar + 2'd1;
            if (ar == 2'd0) whole <= tabs;
            else parts <= parts + tabs;
          end else begin
            tsum <= tsum_new;
            term <= term + 2'd1;
          end
        end
        ST_TEST: begin
          ar <= '0; parts <= '0;
          if (parts <= whole) hit <= 1'b1;
          else if (phase == 1'b0 && sub != 2'd3) begin
            sub <= sub + 2'd1;
            tx[3] <= cx[sub + 2'd1]; ty[3] <= cy[sub + 2'd1];
          end else if (phase == 1'b1 && sub == 2'd0) begin
            sub <= 2'd1;
            tx[1] <= cx[3]; ty[1] <= cy[3];
          end else if (phase == 1'b0 && k + NW'(1) < nlim) begin
            k <= k + NW'(1);
          end else if (phase == 1'b0) begin
            phase <= 1'b1;
            k <= '0;
          end else begin
            k <= k + NW'(1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
